// ===== rtl/core/thl_pkg.sv =====
// Shared constants, command type and helper functions for the timed history lookback block.
package thl_pkg;

   // Geometry of the histories.
   localparam int CHANNELS    = 6;
   localparam int DEPTH       = 160;

   // Field widths of the request and response items.
   localparam int REQ_W       = 2;
   localparam int CHANNEL_W   = 3;
   localparam int ELAPSED_W   = 16;
   localparam int PAYLOAD_W   = 64;
   localparam int TOTAL_W     = 24;

   // Derived widths.
   localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W      = $clog2(DEPTH + 1);
   localparam int ADDR_W      = (CHANNELS * DEPTH > 1) ? $clog2(CHANNELS * DEPTH) : 1;

   // Command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request codes as they arrive on the input channel.
   localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

   // Classified operations handed to the back part.
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd3;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [CH_W-1:0]      ch;
      logic [ELAPSED_W-1:0] elapsed;
      logic [PAYLOAD_W-1:0] payload;
      logic [TOTAL_W-1:0]   target;
   } thl_cmd_type;

   // First record address of a channel's region in the record memory.
   function automatic logic [ADDR_W-1:0] chan_base(input logic [CH_W-1:0] ch);
      return ADDR_W'(ch) * ADDR_W'(DEPTH);
   endfunction

   // Ring slot one step older.
   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] slot);
      return (slot == SLOT_W'(DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
   endfunction

   // Ring slot one step newer.
   function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] slot);
      return (slot == '0) ? SLOT_W'(DEPTH - 1) : slot - SLOT_W'(1);
   endfunction

endpackage

// ===== rtl/core/thl_if.sv =====
// Channel interfaces for request items and response items.
interface thl_req_if;
   import thl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [REQ_W-1:0]     req_type;
   logic [CHANNEL_W-1:0] channel;
   logic [ELAPSED_W-1:0] entry_elapsed_ms;
   logic [PAYLOAD_W-1:0] entry_payload;
   logic [TOTAL_W-1:0]   target_ms;

   modport source (output valid, req_type, channel, entry_elapsed_ms, entry_payload,
                   target_ms, input ready);
   modport sink   (input valid, req_type, channel, entry_elapsed_ms, entry_payload,
                   target_ms, output ready);
endinterface

interface thl_rsp_if;
   import thl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [PAYLOAD_W-1:0] found_payload;
   logic [TOTAL_W-1:0]   total_ms;

   modport source (output valid, found, found_payload, total_ms, input ready);
   modport sink   (input valid, found, found_payload, total_ms, output ready);
endinterface

// ===== rtl/core/thl_front.sv =====
// Front part: accepts request items and classifies them into commands for the back part.
module thl_front (
   thl_req_if.sink              req_chan,
   output logic                 push_valid,
   input  logic                 push_ready,
   output thl_pkg::thl_cmd_type push_cmd
);
   import thl_pkg::*;

   localparam logic [CHANNEL_W:0] CHANNEL_LIMIT = (CHANNEL_W + 1)'(CHANNELS);

   logic chan_ok;

   // A channel beyond the last history turns any request into a no-op.
   assign chan_ok = ({1'b0, req_chan.channel} < CHANNEL_LIMIT);

   // Classify the request and pass its fields on.
   always_comb begin
      push_cmd.ch      = CH_W'(req_chan.channel);
      push_cmd.elapsed = req_chan.entry_elapsed_ms;
      push_cmd.payload = req_chan.entry_payload;
      push_cmd.target  = req_chan.target_ms;
      push_cmd.op      = OP_NOP;
      if (chan_ok) begin
         case (req_chan.req_type)
            REQ_ADD:    push_cmd.op = OP_ADD;
            REQ_CLEAR:  push_cmd.op = OP_CLEAR;
            REQ_LOOKUP: push_cmd.op = OP_LOOKUP;
            default:    push_cmd.op = OP_NOP;
         endcase
      end
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

// ===== rtl/core/thl_queue.sv =====
// Short command queue that decouples the front part from the back part.
module thl_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  thl_pkg::thl_cmd_type push_cmd,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output thl_pkg::thl_cmd_type pop_cmd
);
   import thl_pkg::*;

   thl_cmd_type        entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push, pop;

   function automatic logic [QPTR_W-1:0] ptr_step(input logic [QPTR_W-1:0] ptr);
      return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
   endfunction

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue occupancy beyond its depth");

   assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - QCNT_W'(1))
      else $error("command queue occupancy did not fall on a lone pop");
`endif

endmodule

// ===== rtl/core/thl_back.sv =====
// Back part: record memory, per-channel ring state, lookback walk and response register.
module thl_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  thl_pkg::thl_cmd_type q_cmd,
   thl_rsp_if.source            rsp_chan
);
   import thl_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WALK = 1'b1;

   // Record memory, one region of DEPTH slots per channel.
   logic [PAYLOAD_W-1:0] payload_store_ff [CHANNELS * DEPTH];
   logic [ELAPSED_W-1:0] elapsed_store_ff [CHANNELS * DEPTH];
   logic [PAYLOAD_W-1:0] rd_payload_ff;
   logic [ELAPSED_W-1:0] rd_elapsed_ff;
   logic [ADDR_W-1:0]    rd_addr, wr_addr;
   logic                 wr_en;

   // Per-channel ring state.
   logic [FILL_W-1:0]    fill_ff [CHANNELS];
   logic [FILL_W-1:0]    fill_in [CHANNELS];
   logic [SLOT_W-1:0]    head_ff [CHANNELS];
   logic [SLOT_W-1:0]    head_in [CHANNELS];

   // Walk state.
   logic                 state_ff, state_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [FILL_W-1:0]    k_ff, k_in;
   logic [FILL_W-1:0]    limit_ff, limit_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [TOTAL_W-1:0]   target_ff, target_in;

   // Response register.
   logic                 out_valid_ff, out_valid_in;
   logic                 out_found_ff, out_found_in;
   logic [PAYLOAD_W-1:0] out_payload_ff, out_payload_in;
   logic [TOTAL_W-1:0]   out_total_ff, out_total_in;

   logic                 out_free;
   logic                 at_end, advance;
   logic [TOTAL_W:0]     sum;
   logic [ADDR_W-1:0]    cmd_base;
   logic [SLOT_W-1:0]    cmd_head, new_head, walk_next;

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign cmd_base  = chan_base(q_cmd.ch);
   assign cmd_head  = head_ff[q_cmd.ch];
   assign new_head  = slot_prev(cmd_head);
   assign walk_next = slot_next(slot_ff);

   // The entry whose data sits in the read register is the k-th newest.
   assign at_end  = (k_ff == limit_ff);
   assign advance = (state_ff == S_WALK) && !at_end && (total_ff < target_ff);
   assign sum     = {1'b0, total_ff} + (TOTAL_W + 1)'(rd_elapsed_ff);

   // Command execution and walk sequencing.
   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      head_in        = head_ff;
      base_in        = base_ff;
      slot_in        = slot_ff;
      k_in           = k_ff;
      limit_in       = limit_ff;
      total_in       = total_ff;
      target_in      = target_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_found_in   = out_found_ff;
      out_payload_in = out_payload_ff;
      out_total_in   = out_total_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = cmd_base + ADDR_W'(new_head);
      rd_addr        = base_ff + ADDR_W'(slot_ff);

      case (state_ff)
         S_IDLE: begin
            rd_addr = cmd_base + ADDR_W'(cmd_head);
            if (q_valid && (q_cmd.op == OP_LOOKUP || out_free)) begin
               q_pop = 1'b1;
               if (q_cmd.op == OP_LOOKUP) begin
                  // Start the walk at the newest record of the channel.
                  state_in  = S_WALK;
                  base_in   = cmd_base;
                  slot_in   = cmd_head;
                  k_in      = '0;
                  limit_in  = fill_ff[q_cmd.ch];
                  total_in  = TOTAL_W'(q_cmd.elapsed);
                  target_in = q_cmd.target;
               end else begin
                  // Add, clear and no-op answer at once with an empty result.
                  out_valid_in   = 1'b1;
                  out_found_in   = 1'b0;
                  out_payload_in = '0;
                  out_total_in   = '0;
                  if (q_cmd.op == OP_ADD) begin
                     wr_en              = 1'b1;
                     head_in[q_cmd.ch]  = new_head;
                     if (fill_ff[q_cmd.ch] != FILL_W'(DEPTH)) begin
                        fill_in[q_cmd.ch] = fill_ff[q_cmd.ch] + FILL_W'(1);
                     end
                  end else if (q_cmd.op == OP_CLEAR) begin
                     fill_in[q_cmd.ch] = '0;
                  end
               end
            end
         end
         S_WALK: begin
            if (advance) begin
               // Fold in this record's time and fetch the next older one.
               rd_addr  = base_ff + ADDR_W'(walk_next);
               slot_in  = walk_next;
               k_in     = k_ff + FILL_W'(1);
               total_in = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            end else if (out_free) begin
               // Stopped on a record, or ran past the oldest one.
               state_in       = S_IDLE;
               out_valid_in   = 1'b1;
               out_found_in   = !at_end;
               out_payload_in = at_end ? '0 : rd_payload_ff;
               out_total_in   = total_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            fill_ff[i] <= '0;
            head_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
      end
   end

   // Walk and response data.
   always_ff @(posedge clock) begin
      base_ff        <= base_in;
      slot_ff        <= slot_in;
      k_ff           <= k_in;
      limit_ff       <= limit_in;
      total_ff       <= total_in;
      target_ff      <= target_in;
      out_found_ff   <= out_found_in;
      out_payload_ff <= out_payload_in;
      out_total_ff   <= out_total_in;
   end

   // Record memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         payload_store_ff[wr_addr] <= q_cmd.payload;
         elapsed_store_ff[wr_addr] <= q_cmd.elapsed;
      end
      rd_payload_ff <= payload_store_ff[rd_addr];
      rd_elapsed_ff <= elapsed_store_ff[rd_addr];
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.found         = out_found_ff;
   assign rsp_chan.found_payload = out_payload_ff;
   assign rsp_chan.total_ms      = out_total_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> k_ff <= limit_ff)
      else $error("lookback walk went past the filled records");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK && !advance && out_free && !at_end
      |=> out_found_ff && out_total_ff >= $past(target_ff))
      else $error("record reported before the target was reached");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_found_ff |-> out_payload_ff == '0)
      else $error("payload shown without a found record");
`endif

endmodule

// ===== rtl/core/timed_history_lookback.sv =====
// Add, clear and ignored requests go through the command queue and are answered from
// the response register; a lookup over n records (0 to 160) answers when its walk ends.
// Throughput: one add or clear per cycle while no walk runs and responses are taken;
// a lookup walk holds the back end; the single memory read port yields one record a cycle.
// Reset: fill counts, head pointers, queue and response register are cleared;
// the record memory is not cleared and items are taken as soon as reset is released.
module timed_history_lookback (
   input logic        clock,
   input logic        reset,
   thl_req_if.sink    req_chan,
   thl_rsp_if.source  rsp_chan
);
   import thl_pkg::*;

   logic        push_valid, push_ready;
   thl_cmd_type push_cmd;
   logic        q_valid, q_pop;
   thl_cmd_type q_cmd;

   // Accept and classify request items.
   thl_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // Decouple the front from the back.
   thl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_cmd    (q_cmd)
   );

   // Execute commands against the histories.
   thl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_cmd    (q_cmd),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the timed history lookback block, with its own history predictor.
module testbench;
   import thl_pkg::*;

   // The request code that the block must ignore has no name in the package.
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 200;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [REQ_W-1:0]     kind;
      logic [CHANNEL_W-1:0] channel;
      logic [ELAPSED_W-1:0] elapsed;
      logic [PAYLOAD_W-1:0] payload;
      logic [TOTAL_W-1:0]   target;
   } history_request_type;

   typedef struct packed {
      logic                 found;
      logic [PAYLOAD_W-1:0] payload;
      logic [TOTAL_W-1:0]   total;
   } lookback_answer_type;

   logic clock;
   logic reset;

   thl_req_if req_chan ();
   thl_rsp_if rsp_chan ();

   timed_history_lookback u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted contents of every history.
   logic [PAYLOAD_W-1:0] hist_payload [CHANNELS][DEPTH];
   logic [ELAPSED_W-1:0] hist_elapsed [CHANNELS][DEPTH];
   int unsigned          hist_fill    [CHANNELS];
   int unsigned          hist_head    [CHANNELS];

   lookback_answer_type expected_answers [$];

   int  failures;
   int  answers_checked;
   int  quiet_cycles;
   int  n_add, n_clear, n_lookup, n_found, n_ignored;
   bit  traffic_gaps;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Counts a failure and reports the first few of them.
   task automatic note_failure(input string what);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Applies one accepted item to the predicted histories and returns the answer it causes.
   function automatic lookback_answer_type apply_request(input history_request_type item);
      lookback_answer_type answer;
      int unsigned      ch;
      int unsigned      total;
      int unsigned      steps;
      answer = '0;
      ch     = item.channel;
      if (ch >= CHANNELS || item.kind == REQ_UNUSED) begin
         n_ignored++;
         return answer;
      end
      case (item.kind)
         REQ_ADD: begin
            hist_head[ch] = (hist_head[ch] == 0) ? DEPTH - 1 : hist_head[ch] - 1;
            hist_payload[ch][hist_head[ch]] = item.payload;
            hist_elapsed[ch][hist_head[ch]] = item.elapsed;
            if (hist_fill[ch] < DEPTH)
               hist_fill[ch]++;
            n_add++;
         end
         REQ_CLEAR: begin
            hist_fill[ch] = 0;
            n_clear++;
         end
         default: begin
            // Walk from the newest record while the running total is below the target.
            total = item.elapsed;
            steps = 0;
            while (steps < hist_fill[ch] && total < item.target) begin
               total += hist_elapsed[ch][(hist_head[ch] + steps) % DEPTH];
               if (total > TOTAL_MAX)
                  total = TOTAL_MAX;
               steps++;
            end
            if (steps < hist_fill[ch]) begin
               answer.found   = 1'b1;
               answer.payload = hist_payload[ch][(hist_head[ch] + steps) % DEPTH];
               n_found++;
            end
            answer.total = total[TOTAL_W-1:0];
            n_lookup++;
         end
      endcase
      return answer;
   endfunction

   // Running total after the given number of newest records have been added to a start value.
   function automatic int unsigned lookback_sum(input int unsigned ch, input int unsigned ages,
                                                input int unsigned start);
      int unsigned total;
      total = start;
      for (int unsigned k = 0; k < ages && k < hist_fill[ch]; k++) begin
         total += hist_elapsed[ch][(hist_head[ch] + k) % DEPTH];
         if (total > TOTAL_MAX)
            total = TOTAL_MAX;
      end
      return total;
   endfunction

   // Picks a lookup target, mostly one that lands on or next to a record boundary.
   function automatic logic [TOTAL_W-1:0] lookup_target(input int unsigned ch,
                                                        input int unsigned start);
      int unsigned sel;
      int unsigned nudge;
      int unsigned goal;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return '0;
      if (sel == 1)
         return TOTAL_MAX;
      if (sel == 2)
         return TOTAL_W'($urandom);
      goal  = lookback_sum(ch, $urandom_range(0, hist_fill[ch]), start);
      nudge = $urandom_range(0, 2);
      if (nudge == 0 && goal > 0)
         goal--;
      else if (nudge == 2 && goal < TOTAL_MAX)
         goal++;
      return goal[TOTAL_W-1:0];
   endfunction

   function automatic logic [PAYLOAD_W-1:0] random_payload();
      return {$urandom, $urandom};
   endfunction

   // Mostly short elapsed times so that walks get deep, now and then the full range.
   function automatic logic [ELAPSED_W-1:0] random_elapsed();
      if ($urandom_range(0, 7) == 0)
         return ELAPSED_W'($urandom);
      return ELAPSED_W'($urandom_range(0, 400));
   endfunction

   // Sends one item, with an occasional idle burst before it, and records its answer.
   task automatic send_item(input history_request_type item);
      int gap;
      if (traffic_gaps && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid            <= 1'b1;
      req_chan.req_type         <= item.kind;
      req_chan.channel          <= item.channel;
      req_chan.entry_elapsed_ms <= item.elapsed;
      req_chan.entry_payload    <= item.payload;
      req_chan.target_ms        <= item.target;
      do @(posedge clock); while (!req_chan.ready);
      expected_answers.push_back(apply_request(item));
   endtask

   task automatic issue(input logic [REQ_W-1:0] kind, input int unsigned ch,
                        input logic [ELAPSED_W-1:0] elapsed,
                        input logic [PAYLOAD_W-1:0] payload,
                        input logic [TOTAL_W-1:0] target);
      history_request_type item;
      item.kind    = kind;
      item.channel = CHANNEL_W'(ch);
      item.elapsed = elapsed;
      item.payload = payload;
      item.target  = target;
      send_item(item);
   endtask

   // Lookups on histories that have never been written, valid and invalid channels.
   task automatic test_empty_histories();
      issue(REQ_LOOKUP, 0, '0, random_payload(), '0);
      issue(REQ_LOOKUP, CHANNELS - 1, '1, random_payload(), TOTAL_MAX);
      issue(REQ_LOOKUP, 7, '1, random_payload(), '0);
   endtask

   // Extreme records, then lookups that stop on the newest, on an inner record and past the end.
   task automatic test_add_and_lookup();
      issue(REQ_ADD, 0, '0, '0, TOTAL_W'($urandom));
      issue(REQ_ADD, 0, '1, '1, TOTAL_W'($urandom));
      issue(REQ_ADD, 0, 16'd100, random_payload(), TOTAL_W'($urandom));
      issue(REQ_LOOKUP, 0, '0, random_payload(), '0);
      issue(REQ_LOOKUP, 0, 16'd5, random_payload(), TOTAL_W'(lookback_sum(0, 1, 5)));
      issue(REQ_LOOKUP, 0, '1, random_payload(), TOTAL_MAX);
      // The oldest record has zero elapsed time, so this walk still runs off the end.
      issue(REQ_LOOKUP, 0, 16'd7, random_payload(), TOTAL_W'(lookback_sum(0, 2, 7) + 1));
   endtask

   // The unused request code and invalid channels must leave every history untouched.
   task automatic test_ignored_requests();
      issue(REQ_UNUSED, 0, random_elapsed(), random_payload(), TOTAL_W'($urandom));
      issue(REQ_UNUSED, 7, '1, '1, TOTAL_MAX);
      issue(REQ_ADD, 6, random_elapsed(), random_payload(), TOTAL_W'($urandom));
      issue(REQ_CLEAR, 7, random_elapsed(), random_payload(), TOTAL_W'($urandom));
      issue(REQ_LOOKUP, 6, '1, random_payload(), '0);
      issue(REQ_LOOKUP, 0, '0, random_payload(), TOTAL_MAX);
   endtask

   // Clearing an empty and a filled channel, then refilling it.
   task automatic test_clear();
      issue(REQ_CLEAR, 1, random_elapsed(), random_payload(), TOTAL_W'($urandom));
      issue(REQ_CLEAR, 0, random_elapsed(), random_payload(), TOTAL_W'($urandom));
      issue(REQ_LOOKUP, 0, 16'd42, random_payload(), TOTAL_MAX);
      issue(REQ_ADD, 0, random_elapsed(), random_payload(), TOTAL_W'($urandom));
      issue(REQ_LOOKUP, 0, random_elapsed(), random_payload(), '0);
   endtask

   // Fills one history past its depth so the oldest records are overwritten, then walks it.
   task automatic test_full_history();
      int unsigned  ch;
      logic [15:0]  start;
      ch = 3;
      for (int i = 0; i < DEPTH + 12; i++)
         issue(REQ_ADD, ch, ELAPSED_W'($urandom_range(0, 200)), random_payload(),
               TOTAL_W'($urandom));
      issue(REQ_LOOKUP, ch, random_elapsed(), random_payload(), TOTAL_MAX);
      start = random_elapsed();
      issue(REQ_LOOKUP, ch, start, random_payload(), TOTAL_W'(lookback_sum(ch, DEPTH - 1, start)));
      repeat (6) begin
         start = random_elapsed();
         issue(REQ_LOOKUP, ch, start, random_payload(), lookup_target(ch, start));
      end
   endtask

   // Mixed random traffic: mostly adds and lookups, a few clears and ignored items.
   task automatic test_random_traffic(input int unsigned count);
      history_request_type item;
      int unsigned      pick;
      repeat (count) begin
         item.payload = random_payload();
         item.elapsed = random_elapsed();
         item.target  = TOTAL_W'($urandom);
         item.channel = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
         pick         = $urandom_range(0, 99);
         if (pick < 45) begin
            item.kind = REQ_ADD;
         end else if (pick < 50) begin
            item.kind = REQ_CLEAR;
         end else if (pick < 90) begin
            item.kind   = REQ_LOOKUP;
            item.target = lookup_target(item.channel, item.elapsed);
         end else begin
            item.kind = REQ_W'($urandom_range(0, 3));
            if (item.kind != REQ_UNUSED)
               item.channel = CHANNEL_W'($urandom_range(CHANNELS, 7));
         end
         send_item(item);
      end
   endtask

   // Response ready: random stall bursts while gaps are enabled, otherwise always ready.
   initial begin : rsp_ready_driver
      int hold;
      bit level;
      hold  = 0;
      level = 1'b1;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            if (traffic_gaps && $urandom_range(0, 3) == 0) begin
               level = 1'b0;
               hold  = $urandom_range(1, 18);
            end else begin
               level = 1'b1;
               hold  = $urandom_range(1, 24);
            end
         end
         hold--;
         rsp_chan.ready <= level || !traffic_gaps;
      end
   end

   // Compares each accepted response item with the oldest expected answer.
   always @(posedge clock) begin : answer_checker
      lookback_answer_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_answers.size() == 0) begin
            note_failure("response item arrived with no answer expected");
         end else begin
            want = expected_answers.pop_front();
            answers_checked++;
            if (rsp_chan.found !== want.found)
               note_failure($sformatf("found expected %0b, got %0b", want.found, rsp_chan.found));
            if (rsp_chan.found_payload !== want.payload)
               note_failure($sformatf("found_payload expected %h, got %h",
                                      want.payload, rsp_chan.found_payload));
            if (rsp_chan.total_ms !== want.total)
               note_failure($sformatf("total_ms expected %0d, got %0d",
                                      want.total, rsp_chan.total_ms));
         end
      end
   end

   // Watchdog: ends the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles, %0d answers outstanding.",
                  STALL_LIMIT, expected_answers.size());
         $display("status: fail");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset                     = 1'b1;
      req_chan.valid            = 1'b0;
      req_chan.req_type         = REQ_ADD;
      req_chan.channel          = '0;
      req_chan.entry_elapsed_ms = '0;
      req_chan.entry_payload    = '0;
      req_chan.target_ms        = '0;
      traffic_gaps              = 1'b1;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         hist_fill[ch] = 0;
         hist_head[ch] = 0;
      end
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_empty_histories();
      test_add_and_lookup();
      test_ignored_requests();
      test_clear();
      test_full_history();
      test_random_traffic(300);
      // Final stretch at full rate on both sides.
      traffic_gaps = 1'b0;
      test_random_traffic(120);

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d adds, %0d clears and %0d lookups (%0d found), %0d ignored items.",
               n_add, n_clear, n_lookup, n_found, n_ignored);
      $display("%0d response items checked, %0d failures.", answers_checked, failures);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
